// ----- sv/awv_pkg.sv -----
package awv_pkg;

	// Default ring depth and configuration reset values.
	localparam int DEF_WINDOW = 32;
	localparam logic [47:0] SCALE_RESET = 48'd23040000000;
	localparam logic [5:0] LIMIT_RESET = 6'd8;

	// Fixed field widths.
	localparam int POS_W = 32;
	localparam int TIME_W = 32;
	localparam int VEL_W = 48;
	localparam int SPAN_W = 6;
	localparam int CFG_IDX_W = 2;

	// Scale multiply and divide sizing.
	localparam int HALF_W = 24;
	localparam int PROD_W = 96;
	localparam int DIV_CNT_W = 7;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(PROD_W - 1);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIT_MODE = 2'd0,
		CFG_VEL_SCALE = 2'd1,
		CFG_OUT_LIMIT = 2'd2
	} cfg_idx_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic rd_en;
		logic chk_issue;
		logic [SPAN_W-1:0] back;
		logic [SPAN_W-1:0] span;
		logic span_eval;
		logic acc_load;
		logic mul_step;
		logic [1:0] mul_idx;
		logic div_step;
		logic res_load;
	} awv_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic dt_zero;
		logic chk_busy;
		logic over_limit;
		logic out_free;
	} awv_sts_t;

endpackage

// ----- sv/awv_if.sv -----
// Sample channel: one encoder sample per beat.
interface awv_smp_if;
	logic valid;
	logic ready;
	logic signed [31:0] position;
	logic [31:0] timestamp;
	modport source(output valid, output position, output timestamp, input ready);
	modport sink(input valid, input position, input timestamp, output ready);
endinterface

// Result channel: one velocity estimate per beat.
interface awv_res_if;
	logic valid;
	logic ready;
	logic signed [47:0] velocity;
	logic [5:0] window_span;
	modport source(output valid, output velocity, output window_span, input ready);
	modport sink(input valid, input velocity, input window_span, output ready);
endinterface

// Configuration write channel.
interface awv_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [47:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ----- sv/awv_dp.sv -----
module awv_dp import awv_pkg::*; #(
	parameter int WINDOW = DEF_WINDOW
) (
	input logic clk,
	input logic arst_n,
	input awv_cmd_t cmd,
	output awv_sts_t sts,
	input logic fit_mode,
	input logic [47:0] scale,
	input logic [5:0] limit,
	input logic signed [31:0] in_position,
	input logic [31:0] in_timestamp,
	output logic res_valid,
	input logic res_ready,
	output logic signed [47:0] res_velocity,
	output logic [5:0] res_span
);

	localparam int AW = $clog2(WINDOW);
	localparam int FCT_W = $clog2(WINDOW * (WINDOW + 1) + 1);
	localparam int DEN_W = 32 + FCT_W;
	localparam int NUM_W = 32 + $clog2(3 * WINDOW * WINDOW);
	localparam int DH_W = DEN_W - 32 + 1 + 33;
	localparam int NH_W = NUM_W - 32 + 33;
	localparam int DW = ((DEN_W + 33 > NUM_W + 32) ? DEN_W + 33 : NUM_W + 32) + 1;
	localparam int LIM_W = NUM_W + 3;

	// Ring storage and slot pointer.
	logic [63:0] ring_mem [WINDOW];
	logic [WINDOW-1:0] vld_q;
	logic [AW-1:0] k_q, k_next, rd_addr;
	logic [AW:0] kx, bk;
	logic [63:0] rd_word_q;
	logic rd_ok_q;
	logic signed [31:0] rd_p;
	logic [31:0] rd_t;

	// Item and span state.
	logic signed [31:0] pk_q;
	logic [31:0] tk_q;
	logic signed [NUM_W-1:0] s_q, p_q, s_new, num_q, num_fit, num_end;
	logic signed [AW+32:0] ip;
	logic [FCT_W-1:0] fct_q;
	logic [31:0] dt;
	logic [DEN_W-1:0] den_q, den_new;
	logic [NUM_W-1:0] num_mag;
	logic [LIM_W-1:0] lim5_q;
	logic [5:0] bad_q;

	// Outlier check pipeline.
	logic v_rd_q, v_s1, v_s2;
	logic signed [32:0] dp;
	logic [31:0] age;
	logic signed [65:0] pdl_s1;
	logic signed [DH_W-1:0] pdh_s1;
	logic [63:0] pnl_s1;
	logic signed [NH_W-1:0] pnh_s1;
	logic signed [DW-1:0] d_sum;
	logic [DW-1:0] dabs_s2;
	logic outlier;

	// Accepted span, scale product and division.
	logic signed [NUM_W-1:0] acc_num_q;
	logic [DEN_W-1:0] acc_den_q;
	logic [AW-1:0] acc_span_q;
	logic [47:0] acc_mag;
	logic [HALF_W-1:0] mul_a, mul_b;
	logic [2*HALF_W-1:0] pp;
	logic [PROD_W-1:0] pp_sh, nq_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W:0] r2;
	logic q_big_pos, q_big_neg;
	logic signed [47:0] vel;
	logic res_valid_q;
	logic signed [47:0] res_vel_q;
	logic [5:0] res_span_q;

	// Slot arithmetic modulo the ring depth.
	always_comb begin
		k_next = (k_q == AW'(WINDOW - 1)) ? '0 : k_q + 1'b1;
		kx = {1'b0, k_q};
		bk = {1'b0, cmd.back[AW-1:0]};
		if (kx >= bk) begin
			rd_addr = AW'(kx - bk);
		end else begin
			rd_addr = AW'(kx + (AW+1)'(WINDOW) - bk);
		end
	end

	// Ring memory with registered read.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ring_mem[k_next] <= {in_position, in_timestamp};
		end
		if (cmd.rd_en) begin
			rd_word_q <= ring_mem[rd_addr];
		end
	end

	// Entries never written read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_ok_q <= 1'b0;
			k_q <= '0;
		end else begin
			if (cmd.accept) begin
				vld_q[k_next] <= 1'b1;
				k_q <= k_next;
			end
			if (cmd.rd_en) begin
				rd_ok_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_p = rd_ok_q ? $signed(rd_word_q[63:32]) : '0;
	assign rd_t = rd_ok_q ? rd_word_q[31:0] : '0;

	// Slope of the current span; the best-fit sum is built up one span at a time.
	always_comb begin
		ip = $signed({1'b0, cmd.span[AW-1:0]}) * rd_p;
		s_new = s_q + p_q - NUM_W'(ip);
		num_fit = (s_new <<< 2) + (s_new <<< 1);
		num_end = NUM_W'(pk_q) - NUM_W'(rd_p);
		dt = tk_q - rd_t;
		den_new = dt * fct_q;
		num_mag = num_q[NUM_W-1] ? NUM_W'(-num_q) : num_q;
	end

	always_ff @(posedge clk) begin
		fct_q <= (FCT_W'(cmd.span) + FCT_W'(1)) * (FCT_W'(cmd.span) + FCT_W'(2));
		lim5_q <= LIM_W'({num_mag, 2'b00}) + LIM_W'(num_mag);
		if (cmd.accept) begin
			pk_q <= in_position;
			tk_q <= in_timestamp;
			s_q <= '0;
			p_q <= NUM_W'(in_position);
		end
		if (cmd.span_eval) begin
			s_q <= s_new;
			p_q <= p_q + NUM_W'(rd_p);
			num_q <= fit_mode ? num_fit : num_end;
			den_q <= fit_mode ? den_new : DEN_W'(dt);
		end
	end

	// Outlier pipeline: partial products, sum and magnitude, compare.
	always_comb begin
		dp = 33'(rd_p) - 33'(pk_q);
		age = tk_q - rd_t;
		d_sum = DW'(pdl_s1) + (DW'(pdh_s1) <<< 32) + DW'($signed({1'b0, pnl_s1}))
			+ (DW'(pnh_s1) <<< 32);
		outlier = (dabs_s2 > DW'(den_q)) || (dabs_s2 > DW'(lim5_q));
	end

	always_ff @(posedge clk) begin
		pdl_s1 <= $signed({1'b0, den_q[31:0]}) * dp;
		pdh_s1 <= $signed({1'b0, den_q[DEN_W-1:32]}) * dp;
		pnl_s1 <= num_q[31:0] * age;
		pnh_s1 <= $signed(num_q[NUM_W-1:32]) * $signed({1'b0, age});
		dabs_s2 <= d_sum[DW-1] ? DW'(-d_sum) : DW'(d_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_rd_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			bad_q <= '0;
		end else begin
			v_rd_q <= cmd.chk_issue;
			v_s1 <= v_rd_q;
			v_s2 <= v_s1;
			if (cmd.span_eval) begin
				bad_q <= '0;
			end else if (v_s2 && outlier && bad_q != 6'h3F) begin
				bad_q <= bad_q + 1'b1;
			end
		end
	end

	// Scale product in four 24x24 partial products.
	always_comb begin
		acc_mag = acc_num_q[NUM_W-1] ? 48'(-acc_num_q) : 48'(acc_num_q);
		mul_a = cmd.mul_idx[0] ? scale[47:24] : scale[23:0];
		mul_b = cmd.mul_idx[1] ? acc_mag[47:24] : acc_mag[23:0];
		pp = mul_a * mul_b;
		unique case (cmd.mul_idx)
			2'd0: pp_sh = PROD_W'(pp);
			2'd1, 2'd2: pp_sh = PROD_W'(pp) << HALF_W;
			2'd3: pp_sh = PROD_W'(pp) << (2 * HALF_W);
			default: pp_sh = '0;
		endcase
		r2 = {rem_q, nq_q[PROD_W-1]};
	end

	// Accepted span load, scale product accumulation and restoring division, one quotient bit per step.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			acc_num_q <= '0;
			acc_den_q <= DEN_W'(1);
			acc_span_q <= '0;
		end else if (cmd.acc_load) begin
			acc_num_q <= num_q;
			acc_den_q <= den_q;
			acc_span_q <= cmd.span[AW-1:0];
		end
		if (cmd.mul_step) begin
			nq_q <= ((cmd.mul_idx == 2'd0) ? '0 : nq_q) + pp_sh;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (r2 >= {1'b0, acc_den_q}) begin
				rem_q <= DEN_W'(r2 - {1'b0, acc_den_q});
				nq_q <= {nq_q[PROD_W-2:0], 1'b1};
			end else begin
				rem_q <= DEN_W'(r2);
				nq_q <= {nq_q[PROD_W-2:0], 1'b0};
			end
		end
	end

	// Saturation to the signed Q31.16 range.
	always_comb begin
		q_big_pos = |nq_q[PROD_W-1:47];
		q_big_neg = (|nq_q[PROD_W-1:48]) || (nq_q[47] && (|nq_q[46:0]));
		if (acc_num_q[NUM_W-1]) begin
			vel = q_big_neg ? 48'sh8000_0000_0000 : -$signed(nq_q[47:0]);
		end else begin
			vel = q_big_pos ? 48'sh7FFF_FFFF_FFFF : $signed(nq_q[47:0]);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_vel_q <= vel;
			res_span_q <= 6'(acc_span_q);
		end
	end

	assign res_valid = res_valid_q;
	assign res_velocity = res_vel_q;
	assign res_span = res_span_q;

	assign sts.dt_zero = (tk_q == rd_t);
	assign sts.chk_busy = v_rd_q | v_s1 | v_s2;
	assign sts.over_limit = (bad_q >= limit);
	assign sts.out_free = !res_valid_q || res_ready;

endmodule

// ----- sv/awv_ctrl.sv -----
module awv_ctrl import awv_pkg::*; #(
	parameter int WINDOW = DEF_WINDOW
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input awv_sts_t sts,
	output awv_cmd_t cmd
);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_SPAN_RD = 9'b000000010,
		ST_SPAN_EVAL = 9'b000000100,
		ST_CHK_ISSUE = 9'b000001000,
		ST_CHK_DRAIN = 9'b000010000,
		ST_DECIDE = 9'b000100000,
		ST_MUL = 9'b001000000,
		ST_DIV = 9'b010000000,
		ST_RESULT = 9'b100000000
	} state_t;

	localparam logic [SPAN_W-1:0] LAST_SPAN = SPAN_W'(WINDOW - 1);

	state_t state_q, state_d;
	logic [SPAN_W-1:0] i_q, i_d, j_q, j_d;
	logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		i_d = i_q;
		j_d = j_q;
		cnt_d = cnt_q;
		in_ready = 1'b0;
		cmd = '0;
		cmd.span = i_q;
		cmd.back = i_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					i_d = SPAN_W'(1);
					state_d = ST_SPAN_RD;
				end
			end
			ST_SPAN_RD: begin
				cmd.rd_en = 1'b1;
				state_d = ST_SPAN_EVAL;
			end
			ST_SPAN_EVAL: begin
				cmd.span_eval = 1'b1;
				if (sts.dt_zero) begin
					cnt_d = '0;
					if (i_q == LAST_SPAN) begin
						state_d = ST_MUL;
					end else begin
						i_d = i_q + 1'b1;
						state_d = ST_SPAN_RD;
					end
				end else if (i_q == SPAN_W'(1)) begin
					state_d = ST_DECIDE;
				end else begin
					j_d = SPAN_W'(1);
					state_d = ST_CHK_ISSUE;
				end
			end
			ST_CHK_ISSUE: begin
				cmd.rd_en = 1'b1;
				cmd.chk_issue = 1'b1;
				cmd.back = j_q;
				if (j_q == i_q - 1'b1) begin
					state_d = ST_CHK_DRAIN;
				end else begin
					j_d = j_q + 1'b1;
				end
			end
			ST_CHK_DRAIN: begin
				if (!sts.chk_busy) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cnt_d = '0;
				if (sts.over_limit) begin
					state_d = ST_MUL;
				end else begin
					cmd.acc_load = 1'b1;
					if (i_q == LAST_SPAN) begin
						state_d = ST_MUL;
					end else begin
						i_d = i_q + 1'b1;
						state_d = ST_SPAN_RD;
					end
				end
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				cmd.mul_idx = cnt_q[1:0];
				if (cnt_q[1:0] == 2'd3) begin
					cnt_d = '0;
					state_d = ST_DIV;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_LAST) begin
					state_d = ST_RESULT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q <= '0;
			j_q <= '0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			i_q <= i_d;
			j_q <= j_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

// ----- sv/adaptive_window_velocity.sv -----
// Adaptive-window velocity estimator.
// The smp channel takes one encoder sample (position, microsecond timestamp) per
// beat; the res channel returns one beat per sample: the velocity in deg/s and the
// window span it was measured over. The cfg channel writes fit mode, velocity
// scale and outlier limit; it is always ready. The user must write it only while
// idle; the block itself does not enforce this. Samples are taken one at a time:
// smp.ready is high only while no sample is in work. Each sample is stored in
// the ring, then spans are tried from the shortest up. The single ring read port
// feeds a 3-stage outlier check one sample a cycle with the intermediate samples
// of a span; the shortest span has none, and a span with no time difference is
// skipped. After the search a scale multiply in four partial products and a
// restoring divide give the result.
// The result sits in an output register; a stalled receiver holds it there and
// the next sample can still be accepted, but its result waits for that register.
// Reset clears the ring (through valid bits), the slot pointer and the
// configuration registers; the block is ready for a sample right after reset.
module adaptive_window_velocity import awv_pkg::*; #(
	parameter int WINDOW = DEF_WINDOW
) (
	input logic clk,
	input logic arst_n,
	awv_smp_if.sink smp,
	awv_res_if.source res,
	awv_cfg_if.sink cfg
);

	logic fit_mode_q;
	logic [47:0] scale_q;
	logic [5:0] limit_q;
	awv_cmd_t cmd;
	awv_sts_t sts;

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= 1'b0;
			scale_q <= SCALE_RESET;
			limit_q <= LIMIT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_FIT_MODE: fit_mode_q <= cfg.data[0];
				CFG_VEL_SCALE: scale_q <= cfg.data;
				CFG_OUT_LIMIT: limit_q <= cfg.data[5:0];
				default: ;
			endcase
		end
	end

	awv_ctrl #(.WINDOW(WINDOW)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(smp.valid),
		.in_ready(smp.ready),
		.sts(sts),
		.cmd(cmd)
	);

	awv_dp #(.WINDOW(WINDOW)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.fit_mode(fit_mode_q),
		.scale(scale_q),
		.limit(limit_q),
		.in_position(smp.position),
		.in_timestamp(smp.timestamp),
		.res_valid(res.valid),
		.res_ready(res.ready),
		.res_velocity(res.velocity),
		.res_span(res.window_span)
	);

endmodule

// ----- sv/awv_check.sv -----
module awv_check import awv_pkg::*; #(
	parameter int WINDOW = DEF_WINDOW
) (
	input logic clk,
	input logic arst_n,
	input logic smp_valid,
	input logic smp_ready,
	input logic res_valid,
	input logic res_ready,
	input logic signed [47:0] res_velocity,
	input logic [5:0] res_span
);

	// A result offered and not taken stays offered.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat dropped while stalled");

	// One sample in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp_ready |=> !smp_ready)
		else $error("second sample accepted while busy");

	// The reported span lies inside the ring.
	a_span_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> {1'b0, res_span} < 7'(WINDOW))
		else $error("window span beyond ring depth");

	// No accepted span means zero velocity.
	a_zero_vel: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_span == 6'd0 |-> res_velocity == 48'sd0)
		else $error("nonzero velocity without an accepted span");

endmodule

bind adaptive_window_velocity awv_check #(.WINDOW(WINDOW)) u_awv_check (
	.clk(clk),
	.arst_n(arst_n),
	.smp_valid(smp.valid),
	.smp_ready(smp.ready),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.res_velocity(res.velocity),
	.res_span(res.window_span)
);

// ----- verif/adaptive_window_velocity_test.sv -----
`timescale 1ns / 100ps

module adaptive_window_velocity_test;
	import awv_pkg::*;

	localparam int RING = DEF_WINDOW;
	localparam logic [127:0] VEL_MAX = (128'd1 << 47) - 128'd1;

	typedef struct {
		logic signed [31:0] position;
		logic [31:0] timestamp;
	} sample_t;

	typedef struct {
		logic signed [47:0] velocity;
		logic [5:0] window_span;
	} estimate_t;

	logic clk;
	logic arst_n;

	awv_smp_if smp();
	awv_res_if res();
	awv_cfg_if cfg();

	adaptive_window_velocity uut (
		.clk(clk),
		.arst_n(arst_n),
		.smp(smp),
		.res(res),
		.cfg(cfg)
	);

	sample_t sample_q[$];
	estimate_t estimate_q[$];

	// Shadow of the block's ring and registers.
	logic signed [31:0] ring_pos[RING];
	logic [31:0] ring_time[RING];
	int newest;
	logic shadow_fit;
	logic [47:0] shadow_scale;
	logic [5:0] shadow_limit;

	int errors;
	int samples_sent;
	int estimates_seen;
	int spans_nonzero;
	bit quiet;
	bit smp_fire;
	logic signed [31:0] pos_now;
	logic [31:0] time_now;

	// Work out the velocity estimate caused by one new sample.
	function automatic estimate_t estimate_velocity(input sample_t s);
		estimate_t e;
		int k;
		int old;
		int bad;
		logic [31:0] dt;
		logic [31:0] age;
		longint num;
		longint acc_num;
		longint sum;
		longint dp;
		logic [63:0] den;
		logic [63:0] acc_den;
		logic [63:0] abs_num;
		logic [5:0] acc_span;
		logic signed [127:0] d;
		logic [127:0] mag;
		logic [127:0] q;
		newest = (newest + 1) % RING;
		k = newest;
		ring_pos[k] = s.position;
		ring_time[k] = s.timestamp;
		acc_num = 0;
		acc_den = 1;
		acc_span = 0;
		for (int i = 1; i < RING; i++) begin
			old = (k + RING - i) % RING;
			dt = s.timestamp - ring_time[old];
			if (dt == 0)
				continue;
			if (shadow_fit) begin
				sum = 0;
				for (int l = 0; l <= i; l++)
					sum += longint'(i - 2 * l) * longint'(ring_pos[(k + RING - l) % RING]);
				num = 6 * sum;
				den = 64'(dt) * 64'(i + 1) * 64'(i + 2);
			end else begin
				num = longint'(s.position) - longint'(ring_pos[old]);
				den = 64'(dt);
			end
			abs_num = num < 0 ? 64'(-num) : 64'(num);
			bad = 0;
			// Intermediate samples lying off the line are outliers.
			for (int j = 1; j < i && bad < shadow_limit; j++) begin
				dp = longint'(ring_pos[(k + RING - j) % RING]) - longint'(s.position);
				age = s.timestamp - ring_time[(k + RING - j) % RING];
				d = $signed({64'd0, den}) * $signed({{64{dp[63]}}, dp})
					+ $signed({{64{num[63]}}, num}) * $signed({96'd0, age});
				mag = d < 0 ? 128'(-d) : 128'(d);
				if (mag > {64'd0, den} || mag > 128'(abs_num) * 128'd5)
					bad++;
			end
			if (bad >= shadow_limit)
				break;
			acc_num = num;
			acc_den = den;
			acc_span = 6'(i);
		end
		e.window_span = acc_span;
		e.velocity = '0;
		if (acc_span != 0) begin
			abs_num = acc_num < 0 ? 64'(-acc_num) : 64'(acc_num);
			q = (128'(shadow_scale) * 128'(abs_num)) / 128'(acc_den);
			if (acc_num < 0)
				e.velocity = q > VEL_MAX + 128'd1 ? 48'sh800000000000 : -48'(q);
			else
				e.velocity = q > VEL_MAX ? 48'sh7FFFFFFFFFFF : 48'(q);
		end
		return e;
	endfunction

	// Clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Sample driver: a beat is held until accepted, then the next one may follow a gap.
	always @(negedge clk) begin
		if (arst_n && (!smp.valid || smp_fire)) begin
			if (sample_q.size() != 0 && (quiet || $urandom_range(99) >= 35)) begin
				smp.valid <= 1'b1;
				smp.position <= sample_q[0].position;
				smp.timestamp <= sample_q[0].timestamp;
				void'(sample_q.pop_front());
			end else begin
				smp.valid <= 1'b0;
			end
		end
	end

	// Result receiver stalls at random.
	always @(negedge clk) begin
		if (arst_n)
			res.ready <= quiet || $urandom_range(99) >= 35;
	end

	// Monitor: predict on accepted samples and check accepted results.
	always @(posedge clk) begin
		estimate_t want;
		if (arst_n) begin
			smp_fire <= smp.valid && smp.ready;
			if (smp.valid && smp.ready) begin
				estimate_q.push_back(estimate_velocity('{smp.position, smp.timestamp}));
				samples_sent++;
			end
			if (res.valid && res.ready) begin
				estimates_seen++;
				if (estimate_q.size() == 0) begin
					$error("result beat with no sample pending: velocity %0d span %0d",
						res.velocity, res.window_span);
					errors++;
				end else begin
					want = estimate_q.pop_front();
					if (res.window_span != 0)
						spans_nonzero++;
					if (res.velocity !== want.velocity) begin
						$error("velocity: expected %0d, actual %0d", want.velocity, res.velocity);
						errors++;
					end
					if (res.window_span !== want.window_span) begin
						$error("window_span: expected %0d, actual %0d",
							want.window_span, res.window_span);
						errors++;
					end
				end
			end
		end
	end

	task automatic write_reg(input cfg_idx_t idx, input logic [47:0] value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do
			@(posedge clk);
		while (!cfg.ready);
		case (idx)
			CFG_FIT_MODE: begin
				shadow_fit = value[0];
			end
			CFG_VEL_SCALE: begin
				shadow_scale = value;
			end
			default: begin
				shadow_limit = value[5:0];
			end
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (sample_q.size() != 0 || smp.valid || estimate_q.size() != 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic push_sample(input logic signed [31:0] p, input logic [31:0] t);
		sample_q.push_back('{p, t});
	endtask

	// A motion segment: constant speed with small jitter, with rare glitches,
	// repeated timestamps and full-range junk mixed in.
	task automatic add_motion(input int count, input int glitch_pct);
		int rate;
		int step;
		rate = $urandom_range(1) ? $urandom_range(400) : -int'($urandom_range(400));
		for (int n = 0; n < count; n++) begin
			step = $urandom_range(99) < 5 ? 0 : $urandom_range(1, 50);
			time_now += 32'(step);
			pos_now += 32'(rate * step) + 32'($urandom_range(2)) - 32'sd1;
			if ($urandom_range(99) < glitch_pct)
				push_sample(pos_now + 32'($urandom_range(20000)) - 32'sd10000, time_now);
			else if ($urandom_range(99) < 3)
				push_sample($urandom, $urandom);
			else
				push_sample(pos_now, time_now);
		end
	endtask

	// Reset, configuration phases and stimulus.
	initial begin
		arst_n = 1'b0;
		smp.valid = 1'b0;
		smp.position = '0;
		smp.timestamp = '0;
		res.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = CFG_FIT_MODE;
		cfg.data = '0;
		errors = 0;
		samples_sent = 0;
		estimates_seen = 0;
		spans_nonzero = 0;
		quiet = 1'b0;
		smp_fire = 1'b0;
		for (int n = 0; n < RING; n++) begin
			ring_pos[n] = '0;
			ring_time[n] = '0;
		end
		newest = 0;
		shadow_fit = 1'b0;
		shadow_scale = SCALE_RESET;
		shadow_limit = LIMIT_RESET;
		pos_now = '0;
		time_now = 32'hFFFF_FF00;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: fresh ring, repeated timestamps, position extremes, timer wrap.
		push_sample(32'sd0, 32'd0);
		push_sample(32'sd100, 32'd0);
		push_sample(32'sh7FFFFFFF, 32'd10);
		push_sample(32'sh80000000, 32'd11);
		push_sample(32'sh7FFFFFFF, 32'd12);
		push_sample(32'sd5, 32'hFFFFFFFF);
		push_sample(-32'sd1, 32'hFFFFFFFF);
		for (int n = 0; n < 8; n++)
			push_sample(32'(n * 7), 32'hFFFF_FFFC + 32'(n * 2));
		push_sample(32'sd5000, 32'd13);
		push_sample(32'sd62, 32'd14);
		wait_idle();
		write_reg(CFG_FIT_MODE, 48'd1);
		write_reg(CFG_OUT_LIMIT, 48'd1);
		write_reg(CFG_VEL_SCALE, 48'hFFFF_FFFF_FFFF);
		push_sample(32'sh7FFFFFFF, 32'd20);
		push_sample(32'sh80000000, 32'd21);
		push_sample(32'sh7FFFFFFF, 32'd22);
		push_sample(32'sd0, 32'd22);
		push_sample(-32'sd3, 32'd23);
		wait_idle();

		// Random phases over a spread of settings, one stretch with no stalls.
		for (int ph = 0; ph < 9; ph++) begin
			write_reg(CFG_FIT_MODE, 48'(ph % 2));
			case (ph % 4)
				0: write_reg(CFG_VEL_SCALE, 48'd0);
				1: write_reg(CFG_VEL_SCALE, 48'hFFFF_FFFF_FFFF);
				2: write_reg(CFG_VEL_SCALE, SCALE_RESET);
				default: write_reg(CFG_VEL_SCALE, {16'($urandom_range(65535)), $urandom});
			endcase
			case (ph % 3)
				0: write_reg(CFG_OUT_LIMIT, 48'd63);
				1: write_reg(CFG_OUT_LIMIT, 48'($urandom_range(1, 12)));
				default: write_reg(CFG_OUT_LIMIT, 48'd1);
			endcase
			quiet = ph == 4;
			add_motion(30, 4);
			add_motion(28, 15);
			wait_idle();
		end
		quiet = 1'b0;

		repeat (200) @(negedge clk);
		$display("Covered %0d samples and %0d estimates (%0d over a window) in both fit modes,",
			samples_sent, estimates_seen, spans_nonzero);
		$display("scale and outlier limit at their extremes, with jitter, glitches and wrap.");
		if (errors == 0 && estimate_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			if (estimate_q.size() != 0)
				$error("%0d results never arrived", estimate_q.size());
			$display("== FAIL ==");
		end
		$finish;
	end

	// Run limit.
	initial begin
		#100ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule
